// ===== rtl/pbfa_pkg.sv =====
package pbfa_pkg;

  // Fixed field widths of the item and result channels.
  localparam int WORD_BITS = 16;
  localparam int WB_SH     = 4;
  localparam int OFF_W     = 11;
  localparam int CNT_W     = 5;
  localparam int DATA_W    = 16;
  localparam int CFG_W     = 8;
  localparam int WI_W      = OFF_W - WB_SH;

  localparam logic [CFG_W-1:0] WIU_RESET = 8'd128;

  localparam logic OP_READ    = 1'b0;
  localparam logic OP_WRITE   = 1'b1;
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic clear;
    logic wr0;
    logic wr1;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic err;
    logic zero;
    logic is_write;
    logic straddle;
  } sts_t;

endpackage

// ===== rtl/pbfa_ctrl.sv =====
module pbfa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  pbfa_pkg::sts_t sts,
  output pbfa_pkg::cmd_t cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_WR2   = 3'd3;
  localparam logic [2:0] S_HOLD  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;
  logic       do_write;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;
  assign do_write  = sts.is_write && !sts.err && !sts.zero;

  // Next state and command decode.
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.accept   = in_ready && in_valid;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.wr0 = do_write;
        if (do_write && sts.straddle) begin
          state_nxt = S_WR2;
        end else if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_HOLD;
        end
      end
      S_WR2: begin
        cmd.wr1 = 1'b1;
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // The output slot is full from a load until the item is taken.
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/pbfa_datapath.sv =====
module pbfa_datapath #(
  parameter int STORE_WORDS = 128
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [pbfa_pkg::CFG_W-1:0]    cfg_wr_data,
  input  logic                          in_opcode,
  input  logic [pbfa_pkg::OFF_W-1:0]    in_bit_offset,
  input  logic [pbfa_pkg::CNT_W-1:0]    in_bit_count,
  input  logic [pbfa_pkg::DATA_W-1:0]   in_write_data,
  output logic [pbfa_pkg::DATA_W-1:0]   out_read_data,
  output logic                          out_status,
  input  pbfa_pkg::cmd_t                cmd,
  output pbfa_pkg::sts_t                sts
);

  localparam int W   = pbfa_pkg::WORD_BITS;
  localparam int AW  = $clog2(STORE_WORDS);
  localparam int SW  = $clog2(STORE_WORDS + 1);
  localparam int EW  = (SW > pbfa_pkg::CFG_W) ? SW : pbfa_pkg::CFG_W;
  localparam int BW  = EW + pbfa_pkg::WB_SH;
  localparam int WI  = pbfa_pkg::WI_W;

  logic [W-1:0] mem [STORE_WORDS];

  logic [pbfa_pkg::CFG_W-1:0]  wiu_r;
  logic                        op_r;
  logic [pbfa_pkg::OFF_W-1:0]  off_r;
  logic [pbfa_pkg::CNT_W-1:0]  cnt_r;
  logic [pbfa_pkg::DATA_W-1:0] data_r;
  logic [AW-1:0]               clr_r;
  logic [W-1:0]                rd0_r, rd1_r;
  logic [pbfa_pkg::DATA_W-1:0] rdata_r;
  logic                        status_r;

  logic [pbfa_pkg::OFF_W-1:0]  off_sel;
  logic [WI-1:0]               wo, wo_sel;
  logic [WI:0]                 wo_p1, wo_sel_p1;
  logic [AW-1:0]               ra0, ra1, wa;
  logic                        we;
  logic [W-1:0]                wd;
  logic [3:0]                  bo;
  logic                        nb_valid;
  logic [EW-1:0]               eff, wiu_ext, store_ext;
  logic [BW-1:0]               bound, span;
  logic [pbfa_pkg::DATA_W-1:0] fmask, wfield, field;
  logic [2*W-1:0]              pair, shifted, m2, d2;
  logic [W-1:0]                new0, new1;
  logic                        err;

  function automatic logic [pbfa_pkg::DATA_W-1:0] in_write_data_masked(
    input logic [pbfa_pkg::DATA_W-1:0] d,
    input logic [pbfa_pkg::DATA_W-1:0] m
  );
    return d & m;
  endfunction

  // Word address of the item being accepted, or of the one held.
  assign off_sel   = cmd.accept ? in_bit_offset : off_r;
  assign wo_sel    = off_sel[pbfa_pkg::OFF_W-1:pbfa_pkg::WB_SH];
  assign wo_sel_p1 = {1'b0, wo_sel} + (WI+1)'(1);
  assign ra0       = AW'(wo_sel);
  assign ra1       = AW'(wo_sel_p1);

  // Field geometry of the held item.
  assign wo       = off_r[pbfa_pkg::OFF_W-1:pbfa_pkg::WB_SH];
  assign bo       = off_r[pbfa_pkg::WB_SH-1:0];
  assign wo_p1    = {1'b0, wo} + (WI+1)'(1);
  assign nb_valid = (32'(wo_p1) < STORE_WORDS);
  assign fmask    = pbfa_pkg::DATA_W'(((pbfa_pkg::DATA_W+1)'(1) << cnt_r)
                                      - (pbfa_pkg::DATA_W+1)'(1));

  // Bound check against the words in use, clamped to the store size.
  assign wiu_ext   = EW'(wiu_r);
  assign store_ext = EW'(STORE_WORDS);
  assign eff       = (wiu_ext > store_ext) ? store_ext : wiu_ext;
  assign bound     = {eff, {pbfa_pkg::WB_SH{1'b0}}};
  assign span      = BW'(off_r) + BW'(cnt_r);
  assign err       = (cnt_r > pbfa_pkg::CNT_W'(W)) || (span > bound);

  // Extraction: the neighbour word past the end of the store reads as zero.
  assign pair    = {(nb_valid ? rd1_r : {W{1'b0}}), rd0_r};
  assign shifted = pair >> bo;
  assign field   = shifted[pbfa_pkg::DATA_W-1:0] & fmask;

  // Insertion into the one or two words covered.
  assign wfield = in_write_data_masked(data_r, fmask);
  assign m2     = (2*W)'(fmask) << bo;
  assign d2     = (2*W)'(wfield) << bo;
  assign new0   = (rd0_r & ~m2[W-1:0]) | d2[W-1:0];
  assign new1   = (rd1_r & ~m2[2*W-1:W]) | d2[2*W-1:W];

  assign sts.clear_last = (clr_r == AW'(STORE_WORDS - 1));
  assign sts.err        = err;
  assign sts.zero       = (cnt_r == '0);
  assign sts.is_write   = (op_r == pbfa_pkg::OP_WRITE);
  assign sts.straddle   = ((5'(bo) + cnt_r) > pbfa_pkg::CNT_W'(W)) && nb_valid;

  // Write port selection: clearing pass, first word, second word.
  always_comb begin
    we = 1'b0;
    wa = ra0;
    wd = new0;
    if (cmd.clear) begin
      we = 1'b1;
      wa = clr_r;
      wd = '0;
    end else if (cmd.wr0) begin
      we = 1'b1;
      wa = ra0;
      wd = new0;
    end else if (cmd.wr1) begin
      we = 1'b1;
      wa = ra1;
      wd = new1;
    end
  end

  // Store memory with one write port and two registered read ports.
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd0_r <= mem[ra0];
    rd1_r <= mem[ra1];
  end

  // Clearing pass counter and configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      wiu_r <= pbfa_pkg::WIU_RESET;
    end else begin
      if (cmd.clear) clr_r <= clr_r + AW'(1);
      if (cfg_wr_en) wiu_r <= cfg_wr_data;
    end
  end

  // Item capture and result register.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= in_opcode;
      off_r  <= in_bit_offset;
      cnt_r  <= in_bit_count;
      data_r <= in_write_data;
    end
    if (cmd.load_out) begin
      status_r <= err ? pbfa_pkg::STATUS_ERR : pbfa_pkg::STATUS_OK;
      rdata_r  <= (err || sts.is_write) ? '0 : field;
    end
  end

  assign out_read_data = rdata_r;
  assign out_status    = status_r;

endmodule

// ===== rtl/packed_bit_array_field_access_top.sv =====
// Packed bit store of STORE_WORDS words of 16 bits with field read and write.
// Each item reads or writes a field of up to 16 bits at any bit offset; a
// field may straddle two words. The result is loaded into the output register
// after the store read of its item, or after the second word is written when
// a write covers two words, as the store memory has a single write port and a
// registered read. The next item is taken only once the result is loaded, so
// no item is taken before the last one is through; a result that is not taken
// holds up the next item until the output register frees. After reset a
// clearing pass zeroes the store one word per cycle while in_ready stays low;
// configuration writes are taken as ever.
module packed_bit_array_field_access_top #(
  parameter int STORE_WORDS = 128
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [pbfa_pkg::CFG_W-1:0]  cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_opcode,
  input  logic [pbfa_pkg::OFF_W-1:0]  in_bit_offset,
  input  logic [pbfa_pkg::CNT_W-1:0]  in_bit_count,
  input  logic [pbfa_pkg::DATA_W-1:0] in_write_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [pbfa_pkg::DATA_W-1:0] out_read_data,
  output logic                        out_status
);

  pbfa_pkg::cmd_t cmd;
  pbfa_pkg::sts_t sts;

  // Sequencing of each item.
  pbfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Store, field logic and result register.
  pbfa_datapath #(
    .STORE_WORDS (STORE_WORDS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_opcode     (in_opcode),
    .in_bit_offset (in_bit_offset),
    .in_bit_count  (in_bit_count),
    .in_write_data (in_write_data),
    .out_read_data (out_read_data),
    .out_status    (out_status),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

// ===== rtl/pbfa_checker.sv =====
module pbfa_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [pbfa_pkg::DATA_W-1:0] out_read_data,
  input logic                        out_status
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data) && $stable(out_status))
    else $error("result changed while stalled");

  // A rejected item never carries read data.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == pbfa_pkg::STATUS_ERR) |-> out_read_data == '0)
    else $error("rejected item with non-zero read data");

  // One item at a time: no acceptance in the cycle after one.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted back to back");

  // Reset empties the output and starts the clearing pass.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("block not quiet after reset");

endmodule

bind packed_bit_array_field_access_top pbfa_checker u_pbfa_checker (.*);
